### hdl/dpt_pkg.sv
package dpt_pkg;

  // Command codes carried by the command field. Code 3 has no meaning.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // Bus register selection.
  typedef enum logic [1:0] {
    REG_DIVIDER = 2'd0,
    REG_COUNTER = 2'd1,
    REG_RELOAD  = 2'd2,
    REG_CONTROL = 2'd3
  } reg_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_STEP = 2'd2,
    ST_DONE = 2'd3
  } state_e;

  localparam int unsigned EnableBit   = 2;
  localparam int unsigned PrescaleW   = 12;  // holds prescale plus one tick of cycles

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;     // capture the input item
    logic exec;      // carry out the command's first action
    logic step;      // one counter step of the prescale loop
    logic load_out;  // move the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tick_on;   // command is a tick and the counter is enabled
    logic step_due;  // prescale has reached the selected period
  } dp_status_t;

  function automatic logic [PrescaleW-1:0] period_f(input logic [1:0] sel);
    logic [PrescaleW-1:0] p;
    case (sel)
      2'd0:    p = PrescaleW'(1024);
      2'd1:    p = PrescaleW'(16);
      2'd2:    p = PrescaleW'(64);
      default: p = PrescaleW'(256);
    endcase
    return p;
  endfunction

endpackage

### hdl/dpt_ctrl.sv
module dpt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  dpt_pkg::dp_status_t    status_i,
  output dpt_pkg::ctrl_cmd_t     cmd_o
);

  dpt_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dpt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      dpt_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = dpt_pkg::ST_EXEC;
        end
      end
      dpt_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.tick_on ? dpt_pkg::ST_STEP : dpt_pkg::ST_DONE;
      end
      dpt_pkg::ST_STEP: begin
        if (status_i.step_due) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = dpt_pkg::ST_DONE;
        end
      end
      dpt_pkg::ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = dpt_pkg::ST_IDLE;
        end
      end
      default: state_d = dpt_pkg::ST_IDLE;
    endcase

    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hdl/dpt_datapath.sv
module dpt_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             command_i,
  input  logic [7:0]             cycles_i,
  input  logic [1:0]             reg_index_i,
  input  logic [7:0]             write_data_i,
  input  dpt_pkg::ctrl_cmd_t     cmd_i,
  output dpt_pkg::dp_status_t    status_o,
  output logic [7:0]             read_data_o,
  output logic                   timer_irq_o
);

  localparam int unsigned PW = dpt_pkg::PrescaleW;

  // Captured input item.
  logic [1:0] command_q;
  logic [7:0] cycles_q;
  logic [1:0] reg_index_q;
  logic [7:0] write_data_q;

  // Architectural state.
  logic [7:0]    div_pre_q, div_pre_d;
  logic [7:0]    div_q, div_d;
  logic [PW-1:0] cnt_pre_q, cnt_pre_d;
  logic [7:0]    cnt_q, cnt_d;
  logic [7:0]    reload_q, reload_d;
  logic [7:0]    ctrl_q, ctrl_d;

  // Result under construction and output register.
  logic [7:0] rd_q, rd_d;
  logic       irq_q, irq_d;
  logic [7:0] read_data_q;
  logic       timer_irq_q;

  logic [8:0]    div_sum;
  logic [PW-1:0] period;
  logic [7:0]    cnt_inc;

  assign div_sum = {1'b0, div_pre_q} + {1'b0, cycles_q};
  assign period  = dpt_pkg::period_f(ctrl_q[1:0]);
  assign cnt_inc = cnt_q + 8'd1;

  assign status_o.tick_on  = (dpt_pkg::cmd_e'(command_q) == dpt_pkg::CMD_TICK)
                             && ctrl_q[dpt_pkg::EnableBit];
  assign status_o.step_due = (cnt_pre_q >= period);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      command_q    <= command_i;
      cycles_q     <= cycles_i;
      reg_index_q  <= reg_index_i;
      write_data_q <= write_data_i;
    end
    if (cmd_i.load_out) begin
      read_data_q <= rd_q;
      timer_irq_q <= irq_q;
    end
    rd_q  <= rd_d;
    irq_q <= irq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_pre_q <= '0;
      div_q     <= '0;
      cnt_pre_q <= '0;
      cnt_q     <= '0;
      reload_q  <= '0;
      ctrl_q    <= '0;
    end else begin
      div_pre_q <= div_pre_d;
      div_q     <= div_d;
      cnt_pre_q <= cnt_pre_d;
      cnt_q     <= cnt_d;
      reload_q  <= reload_d;
      ctrl_q    <= ctrl_d;
    end
  end

  always_comb begin
    div_pre_d = div_pre_q;
    div_d     = div_q;
    cnt_pre_d = cnt_pre_q;
    cnt_d     = cnt_q;
    reload_d  = reload_q;
    ctrl_d    = ctrl_q;
    rd_d      = rd_q;
    irq_d     = irq_q;

    if (cmd_i.exec) begin
      rd_d  = 8'd0;
      irq_d = 1'b0;
      unique case (command_q)
        dpt_pkg::CMD_TICK: begin
          // The carry out of the 8-bit prescale is the divider step.
          div_pre_d = div_sum[7:0];
          div_d     = div_q + {7'd0, div_sum[8]};
          if (ctrl_q[dpt_pkg::EnableBit]) begin
            cnt_pre_d = cnt_pre_q + PW'(cycles_q);
          end
        end
        dpt_pkg::CMD_WRITE: begin
          unique case (dpt_pkg::reg_e'(reg_index_q))
            dpt_pkg::REG_DIVIDER: div_d    = write_data_q;
            dpt_pkg::REG_COUNTER: cnt_d    = write_data_q;
            dpt_pkg::REG_RELOAD:  reload_d = write_data_q;
            default:              ctrl_d   = write_data_q;
          endcase
        end
        dpt_pkg::CMD_READ: begin
          unique case (dpt_pkg::reg_e'(reg_index_q))
            dpt_pkg::REG_DIVIDER: rd_d = div_q;
            dpt_pkg::REG_COUNTER: rd_d = cnt_q;
            dpt_pkg::REG_RELOAD:  rd_d = reload_q;
            default:              rd_d = ctrl_q;
          endcase
        end
        default: ;
      endcase
    end

    if (cmd_i.step) begin
      cnt_pre_d = cnt_pre_q - period;
      if (cnt_inc == 8'd0) begin
        cnt_d = reload_q;
        irq_d = 1'b1;
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  assign read_data_o = read_data_q;
  assign timer_irq_o = timer_irq_q;

endmodule

### hdl/divider_and_programmable_timer.sv
// A read, a write or a tick with the counter disabled is captured, executed and then
// loaded into the output register; an enabled tick also steps the counter prescale in
// between, subtracting one period per cycle, for floor((prescale + cycles) / period) steps.
// A new command is taken only after the previous result has been loaded.
// Reset (rst_ni low, asynchronous) clears every timer register and the output valid.
module divider_and_programmable_timer (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Command channel.
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [7:0] cycles_i,
  input  logic [1:0] reg_index_i,
  input  logic [7:0] write_data_i,
  // Result channel.
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       timer_irq_o
);

  // The controller sequences each command: capture, execute, then, for an enabled tick, step
  // the counter prescale once per cycle until it drops below the selected period. The result
  // goes into an output register, so a finished result waiting on a stalled
  // receiver does not stop the next command from being taken in.
  dpt_pkg::ctrl_cmd_t  cmd;
  dpt_pkg::dp_status_t status;

  dpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the divider, counter, reload and control registers and
  // both prescalers. Several counter wraps in one tick each reload the counter,
  // and the interrupt flag of that tick is set once.
  dpt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .command_i    (command_i),
    .cycles_i     (cycles_i),
    .reg_index_i  (reg_index_i),
    .write_data_i (write_data_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .read_data_o  (read_data_o),
    .timer_irq_o  (timer_irq_o)
  );

endmodule

### hdl/dpt_checker.sv
module dpt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_data_o,
  input logic       timer_irq_o
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o)
    && $stable(timer_irq_o))
    else $error("stalled result changed");

  // One command is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("command taken while another is in progress");

  // Only a read returns data, and only a tick raises the interrupt.
  a_irq_or_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(timer_irq_o && (read_data_o != 8'd0)))
    else $error("interrupt and read data in one result");

  // A new result appears as the block becomes free for the next command.
  a_free_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result delivered while still busy");

endmodule

bind divider_and_programmable_timer dpt_checker u_dpt_checker (.*);
